FILE: sv/lfs_pkg.sv
// Shared types and constants for the two-sided Lambert face shader.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lfs_pkg;

   // Results per triangle and the intake gap that follows
   localparam int RSP_PER_ITEM = 3;
   localparam int GAP_W        = $clog2(RSP_PER_ITEM);

   // Q1.10 one
   localparam logic [10:0] ONE_Q10 = 11'd1024;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN    = 3'd4;

   // Reset values of the registers
   localparam logic signed [15:0] RST_LIGHT_X = -16'sd2867;
   localparam logic signed [15:0] RST_LIGHT_Y = -16'sd4506;
   localparam logic signed [15:0] RST_LIGHT_Z = 16'sd6144;
   localparam logic [10:0]        RST_FLOOR   = 11'd164;
   localparam logic [10:0]        RST_SPAN    = 11'd860;

   // Square root and divider sizes
   localparam int ROOT_W = 32;
   localparam int QUOT_W = 11;

   typedef struct packed {
      logic signed [15:0] v0_x;
      logic signed [15:0] v0_y;
      logic signed [15:0] v0_z;
      logic signed [15:0] v1_x;
      logic signed [15:0] v1_y;
      logic signed [15:0] v1_z;
      logic signed [15:0] v2_x;
      logic signed [15:0] v2_y;
      logic signed [15:0] v2_z;
      logic [7:0]         base_red;
      logic [7:0]         base_green;
      logic [7:0]         base_blue;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic [7:0]         lit_red;
      logic [7:0]         lit_green;
      logic [7:0]         lit_blue;
      logic               last_vertex;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
      logic [10:0]        shade_floor;
      logic [10:0]        shade_span;
   } cfg_type;

   // Block-normalized normal, one signed 16-bit lane per axis
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } vec16_type;

   // What travels beside the arithmetic: the item and its flags
   typedef struct packed {
      req_type     item;
      logic        degen;
      logic        lzero;
      logic [31:0] adot;
   } side_type;

endpackage

`default_nettype wire

FILE: sv/two_sided_lambert_face_shader.sv
// Two-sided Lambert face shader: takes one triangle per start and returns its three
// vertices with the face color scaled by floor + span * |cos(normal, light)|.
// A triangle is taken at a clock edge where start is high and busy is low; busy then
// stays high long enough that triangles enter no faster than the single result port
// can send their vertices (three vertices per triangle).
// The first result is v0; v1 and v2 follow it on consecutive cycles. Most of the
// pipeline depth comes from the bit-per-stage square root (33 stages) and the
// bit-per-stage cosine divider (12 stages). The receiver cannot stall: every
// result is shown for exactly one cycle. Write the csr registers only when no
// triangle is in flight. Depends on lfs_pkg and the lfs_* pipeline modules.
`default_nettype none

module two_sided_lambert_face_shader import lfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   cfg_type           cfg_ff;
   logic [GAP_W-1:0]  gap_ff;
   logic              accept;
   logic              fr_valid, co_valid, sq_valid, dv_valid;
   vec16_type         fr_a;
   side_type          fr_side, co_side, sq_side, dv_side;
   logic [63:0]       co_prod;
   logic [ROOT_W-1:0] sq_root;
   logic [QUOT_W-1:0] dv_quot;

   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   // Hold off intake while the result port drains a triangle
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (accept) begin
         gap_ff <= GAP_W'(RSP_PER_ITEM - 1);
      end else if (gap_ff != '0) begin
         gap_ff <= gap_ff - GAP_W'(1);
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_x     <= RST_LIGHT_X;
         cfg_ff.light_y     <= RST_LIGHT_Y;
         cfg_ff.light_z     <= RST_LIGHT_Z;
         cfg_ff.shade_floor <= RST_FLOOR;
         cfg_ff.shade_span  <= RST_SPAN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_X: cfg_ff.light_x     <= csr_wdata;
            CSR_LIGHT_Y: cfg_ff.light_y     <= csr_wdata;
            CSR_LIGHT_Z: cfg_ff.light_z     <= csr_wdata;
            CSR_FLOOR:   cfg_ff.shade_floor <= csr_wdata[10:0];
            CSR_SPAN:    cfg_ff.shade_span  <= csr_wdata[10:0];
            default:     cfg_ff             <= cfg_ff;
         endcase
      end
   end

   lfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (fr_valid),
      .out_a     (fr_a),
      .out_side  (fr_side)
   );

   lfs_cosine u_cosine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (fr_valid),
      .in_a      (fr_a),
      .in_side   (fr_side),
      .out_valid (co_valid),
      .out_prod  (co_prod),
      .out_side  (co_side)
   );

   lfs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (co_valid),
      .in_prod   (co_prod),
      .in_side   (co_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   lfs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_den    (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   lfs_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (dv_valid),
      .in_cos    (dv_quot),
      .in_side   (dv_side),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

FILE: sv/lfs_front.sv
// Front end: edge vectors, cross product and block normalization of the normal.
// Depends on lfs_pkg.
`default_nettype none

module lfs_front import lfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  req_type   in_item,
   output logic      out_valid,
   output vec16_type out_a,
   output side_type  out_side
);

   logic                valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   side_type            side1_ff, side2_ff, side3_ff, side4_ff;
   side_type            side1_in, side3_in;
   logic signed [16:0]  e1_ff [3];
   logic signed [16:0]  e2_ff [3];
   logic signed [16:0]  e1_in [3];
   logic signed [16:0]  e2_in [3];
   logic signed [34:0]  n_ff [3];
   logic signed [34:0]  n_in [3];
   logic [33:0]         mag_ff [3];
   logic [33:0]         mag_in [3];
   logic [2:0]          sgn_ff;
   logic [2:0]          sgn_in;
   logic [33:0]         orv_ff;
   logic [5:0]          msb;
   logic [5:0]          shift;
   logic [33:0]         sh [3];
   vec16_type           a_ff, a_in;

   // Form edge vectors
   always_comb begin
      e1_in[0] = 17'(in_item.v1_x) - 17'(in_item.v0_x);
      e1_in[1] = 17'(in_item.v1_y) - 17'(in_item.v0_y);
      e1_in[2] = 17'(in_item.v1_z) - 17'(in_item.v0_z);
      e2_in[0] = 17'(in_item.v2_x) - 17'(in_item.v0_x);
      e2_in[1] = 17'(in_item.v2_y) - 17'(in_item.v0_y);
      e2_in[2] = 17'(in_item.v2_z) - 17'(in_item.v0_z);
   end

   // Start the side record with the item and cleared flags
   always_comb begin
      side1_in      = '0;
      side1_in.item = in_item;
   end

   // Cross product of the edges
   always_comb begin
      n_in[0] = 35'(e1_ff[1] * e2_ff[2]) - 35'(e1_ff[2] * e2_ff[1]);
      n_in[1] = 35'(e1_ff[2] * e2_ff[0]) - 35'(e1_ff[0] * e2_ff[2]);
      n_in[2] = 35'(e1_ff[0] * e2_ff[1]) - 35'(e1_ff[1] * e2_ff[0]);
   end

   // Split into sign and magnitude, flag a zero normal
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sgn_in[i] = n_ff[i][34];
         mag_in[i] = n_ff[i][34] ? 34'(-n_ff[i]) : 34'(n_ff[i]);
      end
      side3_in       = side2_ff;
      side3_in.degen = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
   end

   // Shift all lanes so the largest fits in 15 bits
   always_comb begin
      msb = '0;
      for (int i = 0; i < 34; i++) begin
         if (orv_ff[i]) begin
            msb = 6'(i);
         end
      end
      shift = (msb > 6'd14) ? (msb - 6'd14) : 6'd0;
      for (int i = 0; i < 3; i++) begin
         sh[i] = mag_ff[i] >> shift;
      end
      a_in.x = sgn_ff[0] ? -$signed(16'(sh[0])) : $signed(16'(sh[0]));
      a_in.y = sgn_ff[1] ? -$signed(16'(sh[1])) : $signed(16'(sh[1]));
      a_in.z = sgn_ff[2] ? -$signed(16'(sh[2])) : $signed(16'(sh[2]));
   end

   // Advance the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
      side1_ff       <= side1_in;
      side2_ff       <= side1_ff;
      side3_ff       <= side3_in;
      side4_ff       <= side3_ff;
      for (int i = 0; i < 3; i++) begin
         e1_ff[i]  <= e1_in[i];
         e2_ff[i]  <= e2_in[i];
         n_ff[i]   <= n_in[i];
         mag_ff[i] <= mag_in[i];
      end
      sgn_ff <= sgn_in;
      orv_ff <= mag_in[0] | mag_in[1] | mag_in[2];
      a_ff   <= a_in;
   end

   assign out_valid = valid4_ff;
   assign out_a     = a_ff;
   assign out_side  = side4_ff;

endmodule

`default_nettype wire

FILE: sv/lfs_cosine.sv
// Dot product, squared lengths and their 64-bit product for the cosine.
// Depends on lfs_pkg.
`default_nettype none

module lfs_cosine import lfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  vec16_type   in_a,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_prod,
   output side_type    out_side
);

   logic signed [15:0] av [3];
   logic signed [15:0] lv [3];
   logic               valid5_ff, valid6_ff, valid7_ff, valid8_ff;
   side_type           side5_ff, side6_ff, side7_ff, side8_ff;
   side_type           side6_in;
   logic signed [31:0] p_ff [3];
   logic [29:0]        q_ff [3];
   logic [30:0]        l_ff [3];
   logic signed [33:0] dot;
   logic [31:0]        nn_ff, ll_ff, ll_in;
   logic [47:0]        pl_ff, ph_ff;
   logic [63:0]        prod_ff;

   always_comb begin
      av[0] = in_a.x;
      av[1] = in_a.y;
      av[2] = in_a.z;
      lv[0] = cfg.light_x;
      lv[1] = cfg.light_y;
      lv[2] = cfg.light_z;
   end

   // Sum the lanes, take the dot magnitude, flag a zero light
   always_comb begin
      dot   = 34'(p_ff[0]) + 34'(p_ff[1]) + 34'(p_ff[2]);
      ll_in = 32'(l_ff[0]) + 32'(l_ff[1]) + 32'(l_ff[2]);
      side6_in       = side5_ff;
      side6_in.adot  = dot[33] ? 32'(-dot) : 32'(dot);
      side6_in.lzero = (ll_in == '0);
   end

   // Advance the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
         valid8_ff <= 1'b0;
      end else begin
         valid5_ff <= in_valid;
         valid6_ff <= valid5_ff;
         valid7_ff <= valid6_ff;
         valid8_ff <= valid7_ff;
      end
      // lane products
      for (int i = 0; i < 3; i++) begin
         p_ff[i] <= av[i] * lv[i];
         q_ff[i] <= 30'(av[i] * av[i]);
         l_ff[i] <= 31'(lv[i] * lv[i]);
      end
      side5_ff <= in_side;
      nn_ff    <= 32'(q_ff[0]) + 32'(q_ff[1]) + 32'(q_ff[2]);
      ll_ff    <= ll_in;
      side6_ff <= side6_in;
      // split the wide product into two 32x16 halves
      pl_ff    <= 48'(nn_ff) * 48'(ll_ff[15:0]);
      ph_ff    <= 48'(nn_ff) * 48'(ll_ff[31:16]);
      side7_ff <= side6_ff;
      prod_ff  <= 64'(pl_ff) + {ph_ff, 16'b0};
      side8_ff <= side7_ff;
   end

   assign out_valid = valid8_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side8_ff;

endmodule

`default_nettype wire

FILE: sv/lfs_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on lfs_pkg.
`default_nettype none

module lfs_sqrt import lfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [63:0]       in_prod,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic              vld_ff  [ROOT_W+1];
   logic [63:0]       rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   side_type          side_ff [ROOT_W+1];

   // Capture the operand
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= in_prod;
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   // Decide one root bit per stage, most significant first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [65:0]       test;
      logic              ge;
      logic [63:0]       rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         test    = (66'(root_ff[k]) << (B + 1)) + (66'(1) << (2 * B));
         ge      = 66'(rem_ff[k]) >= test;
         rem_in  = ge ? 64'(66'(rem_ff[k]) - test) : rem_ff[k];
         root_in = ge ? (root_ff[k] | (ROOT_W'(1) << B)) : root_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

`default_nettype wire

FILE: sv/lfs_div.sv
// Pipelined restoring divider for the Q1.10 cosine, one quotient bit per stage.
// Depends on lfs_pkg.
`default_nettype none

module lfs_div import lfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_den,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [QUOT_W-1:0] out_quot,
   output side_type          out_side
);

   logic              vld_ff  [QUOT_W+1];
   logic [31:0]       rem_ff  [QUOT_W+1];
   logic [ROOT_W-1:0] den_ff  [QUOT_W+1];
   logic [QUOT_W-1:0] quot_ff [QUOT_W+1];
   side_type          side_ff [QUOT_W+1];

   // Capture the operands; the dot magnitude never exceeds the root
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= in_side.adot;
      den_ff[0]  <= in_den;
      quot_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
      localparam int B = QUOT_W - 1 - j;
      logic [32:0]       r2;
      logic              ge;
      logic [31:0]       rem_in;
      logic [QUOT_W-1:0] quot_in;

      // Shift in a zero bit, except on the integer bit
      always_comb begin
         if (j == 0) begin
            r2 = {1'b0, rem_ff[j]};
         end else begin
            r2 = {rem_ff[j], 1'b0};
         end
         ge      = r2 >= {1'b0, den_ff[j]};
         rem_in  = ge ? 32'(r2 - {1'b0, den_ff[j]}) : r2[31:0];
         quot_in = ge ? (quot_ff[j] | (QUOT_W'(1) << B)) : quot_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= vld_ff[j];
         end
         rem_ff[j+1]  <= rem_in;
         den_ff[j+1]  <= den_ff[j];
         quot_ff[j+1] <= quot_in;
         side_ff[j+1] <= side_ff[j];
      end
   end

   assign out_valid = vld_ff[QUOT_W];
   assign out_quot  = quot_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];

endmodule

`default_nettype wire

FILE: sv/lfs_emit.sv
// Shade factor, shaded colors and the three-vertex output sequence.
// Depends on lfs_pkg.
`default_nettype none

module lfs_emit import lfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   input  logic [QUOT_W-1:0] in_cos,
   input  side_type          in_side,
   output logic              rsp_valid,
   output rsp_type           rsp_item
);

   typedef enum logic [1:0] {PH_IDLE, PH_V1, PH_V2} phase_type;

   logic        valida_ff, validb_ff;
   req_type     itema_ff, itemb_ff, hold_ff;
   logic [11:0] shade_ff, shade_in;
   logic [10:0] cc;
   logic [21:0] span_prod;
   logic [7:0]  lit_ff [3];
   logic [7:0]  lit_in [3];
   logic [7:0]  hlit_ff [3];
   logic [7:0]  base [3];
   logic [19:0] cprod [3];
   phase_type   phase_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // Shade from the clamped cosine; degen or zero light overrides
   always_comb begin
      cc        = (in_cos > ONE_Q10) ? ONE_Q10 : in_cos;
      span_prod = 22'(cfg.shade_span) * 22'(cc);
      if (in_side.degen) begin
         shade_in = 12'(cfg.shade_floor) + 12'(cfg.shade_span);
      end else if (in_side.lzero) begin
         shade_in = 12'(cfg.shade_floor);
      end else begin
         shade_in = 12'(cfg.shade_floor) + 12'(span_prod >> 10);
      end
   end

   // Scale and saturate each color
   always_comb begin
      base[0] = itema_ff.base_red;
      base[1] = itema_ff.base_green;
      base[2] = itema_ff.base_blue;
      for (int i = 0; i < 3; i++) begin
         cprod[i]  = 20'(base[i]) * 20'(shade_ff);
         lit_in[i] = (cprod[i][19:10] > 10'd255) ? 8'd255 : cprod[i][17:10];
      end
   end

   // Advance the shade and color stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valida_ff <= 1'b0;
         validb_ff <= 1'b0;
      end else begin
         valida_ff <= in_valid;
         validb_ff <= valida_ff;
      end
      itema_ff <= in_side.item;
      shade_ff <= shade_in;
      itemb_ff <= itema_ff;
      for (int i = 0; i < 3; i++) begin
         lit_ff[i] <= lit_in[i];
      end
   end

   // Send the three vertices on consecutive cycles
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= validb_ff || (phase_ff != PH_IDLE);
         case (phase_ff)
            PH_IDLE: begin
               if (validb_ff) begin
                  phase_ff <= PH_V1;
               end
            end
            PH_V1: begin
               phase_ff <= PH_V2;
            end
            PH_V2: begin
               phase_ff <= PH_IDLE;
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
      // payload follows the phase
      case (phase_ff)
         PH_IDLE: begin
            hold_ff <= itemb_ff;
            for (int i = 0; i < 3; i++) begin
               hlit_ff[i] <= lit_ff[i];
            end
            rsp_ff <= {itemb_ff.v0_x, itemb_ff.v0_y, itemb_ff.v0_z,
                       lit_ff[0], lit_ff[1], lit_ff[2], 1'b0};
         end
         PH_V1: begin
            rsp_ff <= {hold_ff.v1_x, hold_ff.v1_y, hold_ff.v1_z,
                       hlit_ff[0], hlit_ff[1], hlit_ff[2], 1'b0};
         end
         PH_V2: begin
            rsp_ff <= {hold_ff.v2_x, hold_ff.v2_y, hold_ff.v2_z,
                       hlit_ff[0], hlit_ff[1], hlit_ff[2], 1'b1};
         end
         default: begin
            rsp_ff <= rsp_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for two_sided_lambert_face_shader: drives triangles, predicts the three
// shaded vertices of each and checks every strobed result in order.
// Depends on lfs_pkg and the shader RTL.
`default_nettype none

module tb;
   import lfs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 70;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_item;
   logic                 rsp_valid;
   rsp_type              rsp_item;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   two_sided_lambert_face_shader DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the registers
   cfg_type shadow_cfg;

   rsp_type pending_vertices[$];
   int      failures;
   int      idle_cycles;

   // Directed stimulus row: triangle plus an optional typed-in lit color
   typedef struct {
      req_type    tri_item;
      bit         has_lit;
      logic [7:0] lit_r, lit_g, lit_b;
   } tri_row_type;

   tri_row_type directed_rows[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] mag_of(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b, rem;
      r = 0;
      rem = v;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Shade factor of a face under the current light, Q2.10
   function automatic logic [11:0] face_shade_q10(input req_type t);
      logic signed [63:0] e1[3], e2[3], n[3], a[3], lv[3], dotp;
      logic [63:0]        m, nn, ll, den, c;
      int                 s;
      e1[0] = t.v1_x - t.v0_x; e1[1] = t.v1_y - t.v0_y; e1[2] = t.v1_z - t.v0_z;
      e2[0] = t.v2_x - t.v0_x; e2[1] = t.v2_y - t.v0_y; e2[2] = t.v2_z - t.v0_z;
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      if (n[0] == 0 && n[1] == 0 && n[2] == 0)
         return 12'(shadow_cfg.shade_floor) + 12'(shadow_cfg.shade_span);
      lv[0] = shadow_cfg.light_x; lv[1] = shadow_cfg.light_y; lv[2] = shadow_cfg.light_z;
      m = mag_of(n[0]);
      if (mag_of(n[1]) > m) m = mag_of(n[1]);
      if (mag_of(n[2]) > m) m = mag_of(n[2]);
      s = 0;
      while (m >= 64'd32768) begin
         m = m >> 1;
         s++;
      end
      for (int i = 0; i < 3; i++) begin
         a[i] = mag_of(n[i]) >> s;
         if (n[i] < 0) a[i] = -a[i];
      end
      dotp = a[0] * lv[0] + a[1] * lv[1] + a[2] * lv[2];
      nn = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      ll = lv[0] * lv[0] + lv[1] * lv[1] + lv[2] * lv[2];
      if (ll == 0) return 12'(shadow_cfg.shade_floor);
      den = int_sqrt(nn * ll);
      if (den == 0) return 12'(shadow_cfg.shade_floor);
      c = (mag_of(dotp) * 1024) / den;
      if (c > 1024) c = 1024;
      return 12'(shadow_cfg.shade_floor + ((shadow_cfg.shade_span * c) >> 10));
   endfunction

   function automatic logic [7:0] lit_channel(input logic [7:0] base, input logic [11:0] sh);
      logic [31:0] p;
      p = (base * sh) >> 10;
      return p > 255 ? 8'd255 : p[7:0];
   endfunction

   // Queue the three shaded vertices of a triangle
   task automatic predict_vertices(input req_type t);
      logic [11:0] sh;
      rsp_type     r;
      sh = face_shade_q10(t);
      r.lit_red   = lit_channel(t.base_red, sh);
      r.lit_green = lit_channel(t.base_green, sh);
      r.lit_blue  = lit_channel(t.base_blue, sh);
      r.out_x = t.v0_x; r.out_y = t.v0_y; r.out_z = t.v0_z; r.last_vertex = 1'b0;
      pending_vertices = {pending_vertices, r};
      r.out_x = t.v1_x; r.out_y = t.v1_y; r.out_z = t.v1_z;
      pending_vertices = {pending_vertices, r};
      r.out_x = t.v2_x; r.out_y = t.v2_y; r.out_z = t.v2_z; r.last_vertex = 1'b1;
      pending_vertices = {pending_vertices, r};
   endtask

   task automatic idle_wait(input int n);
      repeat (n) @(negedge clock);
   endtask

   // Send one triangle and hold until the shader takes it
   task automatic send_triangle(input req_type t);
      idle_wait($urandom_range(0, 16) * ($urandom_range(0, 3) != 0));
      @(negedge clock);
      start    <= 1'b1;
      req_item <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_vertices(t);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LIGHT_X: shadow_cfg.light_x     = val;
         CSR_LIGHT_Y: shadow_cfg.light_y     = val;
         CSR_LIGHT_Z: shadow_cfg.light_z     = val;
         CSR_FLOOR:   shadow_cfg.shade_floor = val[10:0];
         CSR_SPAN:    shadow_cfg.shade_span  = val[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every vertex is back and the pipe is empty
   task automatic drain_pipe();
      while (pending_vertices.size() != 0) @(negedge clock);
      idle_wait(DRAIN_CYCLES);
   endtask

   task automatic load_config(input logic [15:0] lx, ly, lz, fl, sp);
      drain_pipe();
      csr_write(CSR_LIGHT_X, lx);
      csr_write(CSR_LIGHT_Y, ly);
      csr_write(CSR_LIGHT_Z, lz);
      csr_write(CSR_FLOOR, fl);
      csr_write(CSR_SPAN, sp);
   endtask

   function automatic req_type random_triangle(input int kind);
      req_type      t;
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(req_type)-1:0];
      case (kind)
         0: begin  // three coordinates made small
            t.v0_x = 16'($signed($urandom_range(0, 511)) - 256);
            t.v1_y = 16'($signed($urandom_range(0, 511)) - 256);
            t.v2_z = 16'($signed($urandom_range(0, 511)) - 256);
         end
         1: begin  // collinear: v2 repeats v0
            t.v2_x = t.v0_x; t.v2_y = t.v0_y; t.v2_z = t.v0_z;
         end
         default: ;
      endcase
      return t;
   endfunction

   function automatic req_type make_tri(input logic signed [15:0] ax, ay, az, bx, by, bz,
                                        cx, cy, cz, input logic [7:0] r, g, b);
      req_type t;
      t.v0_x = ax; t.v0_y = ay; t.v0_z = az;
      t.v1_x = bx; t.v1_y = by; t.v1_z = bz;
      t.v2_x = cx; t.v2_y = cy; t.v2_z = cz;
      t.base_red = r; t.base_green = g; t.base_blue = b;
      return t;
   endfunction

   task automatic add_row(input req_type t, input bit has, input logic [7:0] r, g, b);
      tri_row_type row;
      row.tri_item = t; row.has_lit = has;
      row.lit_r = r; row.lit_g = g; row.lit_b = b;
      directed_rows = {directed_rows, row};
   endtask

   // Compare each strobed vertex against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex %h", $time, rsp_item);
            failures++;
         end else begin
            want = pending_vertices.pop_front();
            if (want !== rsp_item) begin
               $display("%0t: vertex mismatch expected %h actual %h", $time, want, rsp_item);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_type t;
      failures    = 0;
      idle_cycles = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      shadow_cfg  = '{RST_LIGHT_X, RST_LIGHT_Y, RST_LIGHT_Z, RST_FLOOR, RST_SPAN};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed faces under reset; degenerate ones get shade 1024, color passes through
      add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd255, 8'd0, 8'd128), 1, 8'd255, 8'd0, 8'd128);
      add_row(make_tri(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768,
                       8'd10, 8'd20, 8'd30), 1, 8'd10, 8'd20, 8'd30);
      add_row(make_tri(0, 0, 0, 16, 0, 0, 0, 16, 0, 8'd255, 8'd255, 8'd255), 0, 0, 0, 0);
      add_row(make_tri(-32768, 32767, 0, 32767, -32768, 1, 0, 0, -32768,
                       8'd200, 8'd1, 8'd77), 0, 0, 0, 0);
      add_row(make_tri(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768,
                       8'd255, 8'd255, 8'd255), 0, 0, 0, 0);
      add_row(make_tri(1, 2, 3, 4, 5, 6, 7, 9, 8, 8'd90, 8'd180, 8'd45), 0, 0, 0, 0);
      foreach (directed_rows[i]) begin
         send_triangle(directed_rows[i].tri_item);
         if (directed_rows[i].has_lit) begin
            pending_vertices[pending_vertices.size()-1].lit_red   = directed_rows[i].lit_r;
            pending_vertices[pending_vertices.size()-1].lit_green = directed_rows[i].lit_g;
            pending_vertices[pending_vertices.size()-1].lit_blue  = directed_rows[i].lit_b;
            for (int k = 2; k <= 3; k++) begin
               pending_vertices[pending_vertices.size()-k].lit_red   = directed_rows[i].lit_r;
               pending_vertices[pending_vertices.size()-k].lit_green = directed_rows[i].lit_g;
               pending_vertices[pending_vertices.size()-k].lit_blue  = directed_rows[i].lit_b;
            end
         end
      end

      // Zero light: shade is the floor; floor and span above one saturate. Then a zero floor, then a zero span
      load_config(16'd0, 16'd0, 16'd0, 16'd2047, 16'd2047);
      send_triangle(make_tri(0, 0, 0, 16, 0, 0, 0, 16, 0, 8'd1, 8'd128, 8'd255));
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd1, 8'd128, 8'd255));
      load_config(16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'd1024);
      send_triangle(make_tri(0, 0, 0, 16, 0, 0, 0, 16, 0, 8'd255, 8'd255, 8'd255));
      send_triangle(make_tri(0, 0, 0, 0, 16, 0, 16, 0, 0, 8'd255, 8'd3, 8'd255));
      load_config(16'h8000, 16'h0000, 16'h0000, 16'd1024, 16'd0);
      send_triangle(make_tri(0, 0, 0, 0, 16, 0, 0, 0, 16, 8'd255, 8'd100, 8'd0));

      // Random phases, each under a new register setting
      for (int ph = 0; ph < 6; ph++) begin
         load_config(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
         for (int i = 0; i < 35; i++) begin
            t = random_triangle($urandom_range(0, 5));
            send_triangle(t);
            // Hold off once per phase until the pipe is empty
            if (i == 17) drain_pipe();
         end
      end

      drain_pipe();
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
